>>> sv/acpu_pkg.sv
`timescale 1ns / 1ps

package acpu_pkg;

   localparam int DATA_W        = 16;
   localparam int ADDR_W        = 15;
   localparam int MEM_WORDS_DEF = 32768;

   // Address wrap: the 16-bit address space is cut into segments no larger
   // than the smallest memory, so each segment holds at most one wrap point.
   localparam int WRAP_SEG  = 1024;
   localparam int SEG_COUNT = (1 << DATA_W) / WRAP_SEG;
   localparam int SEG_BITS  = $clog2(SEG_COUNT);

   localparam logic [DATA_W-1:0] SP_RESET  = 16'h8000;
   localparam logic [DATA_W-1:0] WORD_LOAD = 16'h0001;
   localparam logic [DATA_W-1:0] WORD_STORE = 16'h0002;

   localparam logic [3:0] OP_LOAD  = 4'h1;
   localparam logic [3:0] OP_STORE = 4'h2;
   localparam logic [3:0] OP_ADD   = 4'h3;
   localparam logic [3:0] OP_SUB   = 4'h4;
   localparam logic [3:0] OP_OR    = 4'h5;
   localparam logic [3:0] OP_AND   = 4'h6;
   localparam logic [3:0] OP_XOR   = 4'h7;
   localparam logic [3:0] OP_SHL   = 4'h8;
   localparam logic [3:0] OP_SHR   = 4'h9;
   localparam logic [3:0] OP_MOVE  = 4'ha;
   localparam logic [3:0] OP_JMPE  = 4'hb;
   localparam logic [3:0] OP_JMPM  = 4'hc;
   localparam logic [3:0] OP_PUSH  = 4'hd;
   localparam logic [3:0] OP_POP   = 4'he;
   localparam logic [3:0] OP_LDI   = 4'hf;

   localparam logic [3:0] R_PC     = 4'd0;
   localparam logic [3:0] R_IR     = 4'd1;
   localparam logic [3:0] R_A      = 4'd2;
   localparam logic [3:0] R_B      = 4'd3;
   localparam logic [3:0] R_C      = 4'd4;
   localparam logic [3:0] R_D      = 4'd5;
   localparam logic [3:0] R_E      = 4'd6;
   localparam logic [3:0] R_SP     = 4'd7;
   localparam logic [3:0] R_SB     = 4'd8;
   localparam logic [3:0] R_STATUS = 4'd9;

   typedef enum logic [1:0] {
      CMD_EXEC  = 2'd0,
      CMD_WRITE = 2'd1,
      CMD_READ  = 2'd2
   } cmd_type;

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_EXEC,
      ST_MEM2,
      ST_READ,
      ST_HOLD
   } state_type;

   // First member sits in the highest bits, so pc lands in the lowest bits.
   typedef struct packed {
      logic [DATA_W-1:0] read_data;
      logic [DATA_W-1:0] status_out;
      logic [DATA_W-1:0] sp_out;
      logic [DATA_W-1:0] e_out;
      logic [DATA_W-1:0] d_out;
      logic [DATA_W-1:0] c_out;
      logic [DATA_W-1:0] b_out;
      logic [DATA_W-1:0] a_out;
      logic [DATA_W-1:0] ir_out;
      logic [DATA_W-1:0] pc_out;
   } rsp_type;

   localparam int RSP_W = $bits(rsp_type);

endpackage

>>> sv/acpu_ram.sv
`timescale 1ns / 1ps

module acpu_ram #(
   parameter int WIDTH = 16,
   parameter int DEPTH = 1024
) (
   input  logic                     clock,
   input  logic                     en,
   input  logic                     we,
   input  logic [$clog2(DEPTH)-1:0] addr,
   input  logic [WIDTH-1:0]         wdata,
   output logic [WIDTH-1:0]         rdata
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rdata_ff;

   always_ff @(posedge clock) begin
      if (en) begin
         if (we) begin
            mem_ff[addr] <= wdata;
         end else begin
            rdata_ff <= mem_ff[addr];
         end
      end
   end

   assign rdata = rdata_ff;

endmodule

>>> sv/accumulator_cpu_step.sv
`timescale 1ns / 1ps

// Small 16-bit accumulator CPU driven one command at a time.
// Request channel (req_): tuser carries the command (execute one instruction,
// write a memory word, read a memory word); tdata carries the word address
// and the write data. Each request transfer yields exactly one response
// transfer on the rsp_ channel with pc, ir, a, b, c, d, e, sp, status and the
// read word (zero unless the command was a read), in request order.
// A request lands in a one-entry input buffer and starts once the control is idle.
// Work per command, set by the single-port synchronous word memory:
//   write or unknown command: done from idle; read: memory read, then answer;
//   instruction: fetch, execute, plus a second read for load, pop,
//   load immediate and a taken inline jump (fetch, execute, second read).
// The buffer reopens the cycle after its command starts, so the next request
// can be taken while a command is still at work.
// If the response register is still full when a command finishes, the block
// waits with the new state committed until the receiver takes the old one;
// the input buffer still takes one more request meanwhile.
// Reset (synchronous) restores the register file, empties both buffers and
// leaves the memory contents undefined; reading a word never written gives
// an undefined value. MEM_WORDS must be at least 1024.

module accumulator_cpu_step import acpu_pkg::*; #(
   parameter int MEM_WORDS = MEM_WORDS_DEF
) (
   input  logic             clock,
   input  logic             reset,
   input  logic             req_tvalid,
   output logic             req_tready,
   input  logic [31:0]      req_tdata,   // address[14:0], data[30:15], zero pad
   input  logic [1:0]       req_tuser,   // command[1:0]
   output logic             rsp_tvalid,
   input  logic             rsp_tready,
   output logic [RSP_W-1:0] rsp_tdata    // pc, ir, a, b, c, d, e, sp, status, read_data
);

   localparam int AW = $clog2(MEM_WORDS);
   localparam logic [DATA_W:0] MEM_LIM = (DATA_W+1)'(MEM_WORDS);

   state_type state_ff, state_in;

   logic              pend_valid_ff, pend_valid_in;
   cmd_type           pend_cmd_ff;
   logic [ADDR_W-1:0] pend_addr_ff;
   logic [DATA_W-1:0] pend_data_ff;

   logic [DATA_W-1:0] pc_ff, pc_in, ir_ff, ir_in, a_ff, a_in, b_ff, b_in;
   logic [DATA_W-1:0] c_ff, c_in, d_ff, d_in, e_ff, e_in, sp_ff, sp_in;
   logic [DATA_W-1:0] sb_ff, sb_in, status_ff, status_in;

   logic              rsp_valid_ff, rsp_valid_in;
   rsp_type           rsp_data_ff, rsp_data_in;
   logic [DATA_W-1:0] rd_hold_ff, rd_hold_in;

   logic              req_take, pend_take, out_free, done, out_load;
   logic [DATA_W-1:0] rd_val;

   logic              ram_en, ram_we;
   logic [DATA_W-1:0] ram_addr_raw, ram_wdata, ram_rdata;
   logic [AW-1:0]     ram_addr;
   logic [DATA_W:0]   wrap_base [SEG_COUNT];
   logic [DATA_W:0]   wrap_diff, wrap_rem;

   logic [DATA_W-1:0] word, pc_inc, vx, vy, alu_res, wr_val;
   logic [3:0]        op, cond, idx_x, idx_y, wr_idx;
   logic              taken, exec_second, wr_en;
   logic [DATA_W-1:0] reg_view [16];

   // ---------------- input buffer ----------------
   assign req_tready    = !pend_valid_ff;
   assign req_take      = req_tvalid && req_tready;
   assign pend_take     = (state_ff == ST_IDLE) && pend_valid_ff;
   assign pend_valid_in = req_take || (pend_valid_ff && !pend_take);

   always_ff @(posedge clock) begin
      if (req_take) begin
         pend_cmd_ff  <= cmd_type'(req_tuser);
         pend_addr_ff <= req_tdata[ADDR_W-1:0];
         pend_data_ff <= req_tdata[ADDR_W +: DATA_W];
      end
   end

   // ---------------- memory and address wrap ----------------
   // Each 1024-word segment of the address space maps to one wrap base; what
   // remains after subtracting it is below twice the memory size.
   for (genvar k = 0; k < SEG_COUNT; k++) begin : g_wrap
      localparam int unsigned BASE = ((k * WRAP_SEG) / MEM_WORDS) * MEM_WORDS;
      assign wrap_base[k] = (DATA_W+1)'(BASE);
   end

   assign wrap_diff = {1'b0, ram_addr_raw} - wrap_base[ram_addr_raw[DATA_W-1 -: SEG_BITS]];
   assign wrap_rem  = (wrap_diff >= MEM_LIM) ? (wrap_diff - MEM_LIM) : wrap_diff;
   assign ram_addr  = wrap_rem[AW-1:0];

   acpu_ram #(
      .WIDTH (DATA_W),
      .DEPTH (MEM_WORDS)
   ) u_ram (
      .clock (clock),
      .en    (ram_en),
      .we    (ram_we),
      .addr  (ram_addr),
      .wdata (ram_wdata),
      .rdata (ram_rdata)
   );

   // ---------------- decode of the fetched word ----------------
   assign word   = ram_rdata;
   assign op     = word[3:0];
   assign cond   = word[7:4];
   assign idx_x  = word[11:8];
   assign idx_y  = word[15:12];
   assign pc_inc = pc_ff + 16'd1;
   assign taken  = (cond & ~status_ff[3:0]) == 4'd0;

   // Register reads during execute see the fetch already applied.
   always_comb begin
      for (int i = 0; i < 16; i++) begin
         reg_view[i] = '0;
      end
      reg_view[R_PC]     = pc_inc;
      reg_view[R_IR]     = word;
      reg_view[R_A]      = a_ff;
      reg_view[R_B]      = b_ff;
      reg_view[R_C]      = c_ff;
      reg_view[R_D]      = d_ff;
      reg_view[R_E]      = e_ff;
      reg_view[R_SP]     = sp_ff;
      reg_view[R_SB]     = sb_ff;
      reg_view[R_STATUS] = status_ff;
   end

   assign vx = reg_view[idx_x];
   assign vy = reg_view[idx_y];

   assign exec_second = (word == WORD_LOAD) || (op == OP_POP) || (op == OP_LDI)
                        || ((op == OP_JMPM) && taken);

   always_comb begin
      case (op)
         OP_ADD:  alu_res = vx + vy;
         OP_SUB:  alu_res = vx - vy;
         OP_OR:   alu_res = vx | vy;
         OP_AND:  alu_res = vx & vy;
         OP_XOR:  alu_res = vx ^ vy;
         OP_SHL:  alu_res = (vy >= 16'd16) ? '0 : (vx << vy[3:0]);
         OP_SHR:  alu_res = (vy >= 16'd16) ? '0 : (vx >> vy[3:0]);
         default: alu_res = a_ff;
      endcase
   end

   // ---------------- control ----------------
   assign out_free = !rsp_valid_ff || rsp_tready;

   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         ST_IDLE: begin
            if (pend_valid_ff) begin
               case (pend_cmd_ff)
                  CMD_EXEC: state_in = ST_EXEC;
                  CMD_READ: state_in = ST_READ;
                  default:  state_in = out_free ? ST_IDLE : ST_HOLD;
               endcase
            end
         end
         ST_EXEC: begin
            if (exec_second) begin
               state_in = ST_MEM2;
            end else begin
               state_in = out_free ? ST_IDLE : ST_HOLD;
            end
         end
         ST_MEM2, ST_READ: begin
            state_in = out_free ? ST_IDLE : ST_HOLD;
         end
         ST_HOLD: begin
            if (out_free) begin
               state_in = ST_IDLE;
            end
         end
         default: state_in = ST_IDLE;
      endcase
   end

   always_comb begin
      pc_in        = pc_ff;
      ir_in        = ir_ff;
      a_in         = a_ff;
      b_in         = b_ff;
      c_in         = c_ff;
      d_in         = d_ff;
      e_in         = e_ff;
      sp_in        = sp_ff;
      sb_in        = sb_ff;
      status_in    = status_ff;
      ram_en       = 1'b0;
      ram_we       = 1'b0;
      ram_addr_raw = pc_ff;
      ram_wdata    = a_ff;
      done         = 1'b0;
      rd_val       = '0;
      wr_en        = 1'b0;
      wr_idx       = idx_x;
      wr_val       = vx;

      unique case (state_ff)
         ST_IDLE: begin
            if (pend_valid_ff) begin
               case (pend_cmd_ff)
                  CMD_EXEC: begin
                     ram_en = 1'b1;
                  end
                  CMD_WRITE: begin
                     ram_en       = 1'b1;
                     ram_we       = 1'b1;
                     ram_addr_raw = {1'b0, pend_addr_ff};
                     ram_wdata    = pend_data_ff;
                     done         = 1'b1;
                  end
                  CMD_READ: begin
                     ram_en       = 1'b1;
                     ram_addr_raw = {1'b0, pend_addr_ff};
                  end
                  default: done = 1'b1;
               endcase
            end
         end
         ST_EXEC: begin
            pc_in = pc_inc;
            ir_in = word;
            done  = !exec_second;
            case (op) inside
               OP_LOAD: begin
                  if (word == WORD_LOAD) begin
                     ram_en       = 1'b1;
                     ram_addr_raw = b_ff;
                  end
               end
               OP_STORE: begin
                  if (word == WORD_STORE) begin
                     ram_en       = 1'b1;
                     ram_we       = 1'b1;
                     ram_addr_raw = b_ff;
                  end
               end
               OP_ADD, OP_SUB, OP_OR, OP_AND, OP_XOR, OP_SHL, OP_SHR: begin
                  a_in = alu_res;
               end
               OP_MOVE: begin
                  wr_en  = 1'b1;
                  wr_idx = idx_y;
               end
               OP_JMPE: begin
                  if (taken) begin
                     pc_in = e_ff;
                  end
               end
               OP_JMPM: begin
                  if (taken) begin
                     ram_en       = 1'b1;
                     ram_addr_raw = pc_inc;
                  end else begin
                     pc_in = pc_inc + 16'd1;
                  end
               end
               OP_PUSH: begin
                  ram_en       = 1'b1;
                  ram_we       = 1'b1;
                  ram_addr_raw = sp_ff;
                  sp_in        = sp_ff - 16'd1;
               end
               OP_POP: begin
                  ram_en       = 1'b1;
                  ram_addr_raw = sp_ff + 16'd1;
                  sp_in        = sp_ff + 16'd1;
               end
               OP_LDI: begin
                  ram_en       = 1'b1;
                  ram_addr_raw = pc_inc;
                  pc_in        = pc_inc + 16'd1;
               end
               default: ;
            endcase
         end
         ST_MEM2: begin
            // The instruction register still holds the word decoded above.
            done = 1'b1;
            case (ir_ff[3:0]) inside
               OP_LOAD, OP_POP: a_in = ram_rdata;
               OP_JMPM:         pc_in = ram_rdata;
               OP_LDI: begin
                  wr_en  = 1'b1;
                  wr_idx = ir_ff[11:8];
                  wr_val = ram_rdata;
               end
               default: ;
            endcase
         end
         ST_READ: begin
            rd_val = ram_rdata;
            done   = 1'b1;
         end
         ST_HOLD: ;
         default: ;
      endcase

      if (wr_en) begin
         unique case (wr_idx)
            R_PC:     pc_in     = wr_val;
            R_IR:     ir_in     = wr_val;
            R_A:      a_in      = wr_val;
            R_B:      b_in      = wr_val;
            R_C:      c_in      = wr_val;
            R_D:      d_in      = wr_val;
            R_E:      e_in      = wr_val;
            R_SP:     sp_in     = wr_val;
            R_SB:     sb_in     = wr_val;
            R_STATUS: status_in = wr_val;
            default:  ;
         endcase
      end
   end

   // ---------------- response register ----------------
   assign out_load   = out_free && (done || (state_ff == ST_HOLD));
   assign rd_hold_in = done ? rd_val : rd_hold_ff;

   always_comb begin
      // While holding, the registers are already committed and stay put.
      rsp_data_in.read_data  = done ? rd_val : rd_hold_ff;
      rsp_data_in.status_out = status_in;
      rsp_data_in.sp_out     = sp_in;
      rsp_data_in.e_out      = e_in;
      rsp_data_in.d_out      = d_in;
      rsp_data_in.c_out      = c_in;
      rsp_data_in.b_out      = b_in;
      rsp_data_in.a_out      = a_in;
      rsp_data_in.ir_out     = ir_in;
      rsp_data_in.pc_out     = pc_in;
   end

   assign rsp_valid_in = out_load || (rsp_valid_ff && !rsp_tready);

   always_ff @(posedge clock) begin
      if (out_load) begin
         rsp_data_ff <= rsp_data_in;
      end
      rd_hold_ff <= rd_hold_in;
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = rsp_data_ff;

   // ---------------- control and register file state ----------------
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff      <= ST_IDLE;
         pend_valid_ff <= 1'b0;
         rsp_valid_ff  <= 1'b0;
         pc_ff         <= '0;
         ir_ff         <= '0;
         a_ff          <= '0;
         b_ff          <= '0;
         c_ff          <= '0;
         d_ff          <= '0;
         e_ff          <= '0;
         sp_ff         <= SP_RESET;
         sb_ff         <= SP_RESET;
         status_ff     <= '0;
      end else begin
         state_ff      <= state_in;
         pend_valid_ff <= pend_valid_in;
         rsp_valid_ff  <= rsp_valid_in;
         pc_ff         <= pc_in;
         ir_ff         <= ir_in;
         a_ff          <= a_in;
         b_ff          <= b_in;
         c_ff          <= c_in;
         d_ff          <= d_in;
         e_ff          <= e_in;
         sp_ff         <= sp_in;
         sb_ff         <= sb_in;
         status_ff     <= status_in;
      end
   end

endmodule

>>> sv/acpu_checker.sv
`timescale 1ns / 1ps

module acpu_checker import acpu_pkg::*; (
   input logic             clock,
   input logic             reset,
   input logic             req_tvalid,
   input logic             req_tready,
   input logic             rsp_tvalid,
   input logic             rsp_tready,
   input logic [RSP_W-1:0] rsp_tdata
);

   // Requests taken but not yet answered: input buffer, the command at work
   // and the response register hold at most three between them.
   logic [2:0] cnt_ff, cnt_in;
   logic       req_xfer, rsp_xfer;

   assign req_xfer = req_tvalid && req_tready;
   assign rsp_xfer = rsp_tvalid && rsp_tready;
   assign cnt_in   = cnt_ff + {2'b00, req_xfer} - {2'b00, rsp_xfer};

   always_ff @(posedge clock) begin
      if (reset) begin
         cnt_ff <= '0;
      end else begin
         cnt_ff <= cnt_in;
      end
   end

   a_no_spurious_rsp: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid |-> cnt_ff != 3'd0)
      else $error("response offered with no request outstanding");

   a_outstanding_bound: assert property (@(posedge clock) disable iff (reset)
      cnt_ff <= 3'd3)
      else $error("more requests outstanding than the block can hold");

   a_buffer_fills: assert property (@(posedge clock) disable iff (reset)
      req_xfer |=> !req_tready)
      else $error("input buffer did not close after a transfer");

   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && !rsp_tready |=> rsp_tvalid && $stable(rsp_tdata))
      else $error("stalled response changed");

   a_reset_clears: assert property (@(posedge clock)
      reset |=> !rsp_tvalid && req_tready)
      else $error("reset did not empty the buffers");

endmodule

bind accumulator_cpu_step acpu_checker u_acpu_checker (.*);

>>> sim/tb_accumulator_cpu_step.sv
`timescale 1ns / 1ps

module tb_accumulator_cpu_step;
   import acpu_pkg::*;

   // The fourth command code has no meaning; the block must leave all state alone.
   localparam logic [1:0] CMD_UNKNOWN = 2'd3;
   localparam int RANDOM_ITEMS = 500;

   // Shadow copy of the CPU plus the queue of register snapshots still owed by the block.
   class cpu_state_checker;
      logic [DATA_W-1:0] regs [10];
      logic [DATA_W-1:0] mem [MEM_WORDS_DEF];
      bit                written [MEM_WORDS_DEF];
      int                written_list [$];
      rsp_type           expected_regs [$];
      int                errors;
      int                checked;

      function new();
         foreach (regs[i]) regs[i] = '0;
         regs[R_SP] = SP_RESET;
         regs[R_SB] = SP_RESET;
         errors = 0;
         checked = 0;
      endfunction

      function int wrap(logic [DATA_W-1:0] a);
         return int'(a) % MEM_WORDS_DEF;
      endfunction

      function logic [DATA_W-1:0] read_reg(logic [3:0] idx);
         if (idx <= R_STATUS) return regs[idx];
         return '0;
      endfunction

      function void write_reg(logic [3:0] idx, logic [DATA_W-1:0] v);
         if (idx <= R_STATUS) regs[idx] = v;
      endfunction

      function logic [DATA_W-1:0] read_mem(logic [DATA_W-1:0] a);
         return mem[wrap(a)];
      endfunction

      function void write_mem(logic [DATA_W-1:0] a, logic [DATA_W-1:0] v);
         int idx;
         idx = wrap(a);
         if (!written[idx]) begin
            written[idx] = 1'b1;
            written_list.push_back(idx);
         end
         mem[idx] = v;
      endfunction

      function bit cond_met(logic [3:0] cond);
         return (cond & ~regs[R_STATUS][3:0]) == 4'd0;
      endfunction

      function void execute_word();
         logic [DATA_W-1:0] w, vx, vy, imm;
         logic [3:0] op, cond, x, y;
         w = read_mem(regs[R_PC]);
         regs[R_IR] = w;
         regs[R_PC] = regs[R_PC] + 16'd1;
         op = w[3:0];
         cond = w[7:4];
         x = w[11:8];
         y = w[15:12];
         // Operands are read after the fetch, so pc and ir show their new values.
         vx = read_reg(x);
         vy = read_reg(y);
         case (op)
            OP_LOAD: begin
               if (w == WORD_LOAD) regs[R_A] = read_mem(regs[R_B]);
            end
            OP_STORE: begin
               if (w == WORD_STORE) write_mem(regs[R_B], regs[R_A]);
            end
            OP_ADD: regs[R_A] = vx + vy;
            OP_SUB: regs[R_A] = vx - vy;
            OP_OR:  regs[R_A] = vx | vy;
            OP_AND: regs[R_A] = vx & vy;
            OP_XOR: regs[R_A] = vx ^ vy;
            OP_SHL: regs[R_A] = (vy >= 16) ? '0 : vx << vy[3:0];
            OP_SHR: regs[R_A] = (vy >= 16) ? '0 : vx >> vy[3:0];
            OP_MOVE: write_reg(y, vx);
            OP_JMPE: begin
               if (cond_met(cond)) regs[R_PC] = regs[R_E];
            end
            OP_JMPM: begin
               if (cond_met(cond)) regs[R_PC] = read_mem(regs[R_PC]);
               else regs[R_PC] = regs[R_PC] + 16'd1;
            end
            OP_PUSH: begin
               write_mem(regs[R_SP], regs[R_A]);
               regs[R_SP] = regs[R_SP] - 16'd1;
            end
            OP_POP: begin
               regs[R_SP] = regs[R_SP] + 16'd1;
               regs[R_A] = read_mem(regs[R_SP]);
            end
            OP_LDI: begin
               imm = read_mem(regs[R_PC]);
               regs[R_PC] = regs[R_PC] + 16'd1;
               write_reg(x, imm);
            end
            default: ;
         endcase
      endfunction

      function void apply_command(logic [1:0] cmd, logic [ADDR_W-1:0] addr,
                                  logic [DATA_W-1:0] data);
         rsp_type snap;
         snap = '0;
         case (cmd)
            CMD_EXEC:  execute_word();
            CMD_WRITE: write_mem({1'b0, addr}, data);
            CMD_READ:  snap.read_data = read_mem({1'b0, addr});
            default: ;
         endcase
         snap.pc_out     = regs[R_PC];
         snap.ir_out     = regs[R_IR];
         snap.a_out      = regs[R_A];
         snap.b_out      = regs[R_B];
         snap.c_out      = regs[R_C];
         snap.d_out      = regs[R_D];
         snap.e_out      = regs[R_E];
         snap.sp_out     = regs[R_SP];
         snap.status_out = regs[R_STATUS];
         expected_regs.push_back(snap);
      endfunction

      function void compare_field(string name, logic [DATA_W-1:0] exp_v,
                                  logic [DATA_W-1:0] act_v);
         if (act_v !== exp_v) begin
            errors++;
            $display("%0t: %s mismatch, expected %h, actual %h", $time, name, exp_v, act_v);
         end
      endfunction

      function void check_snapshot(rsp_type got);
         rsp_type snap;
         checked++;
         if (expected_regs.size() == 0) begin
            errors++;
            $display("%0t: unexpected response, expected none, actual %h", $time, got);
            return;
         end
         snap = expected_regs.pop_front();
         compare_field("pc", snap.pc_out, got.pc_out);
         compare_field("ir", snap.ir_out, got.ir_out);
         compare_field("a", snap.a_out, got.a_out);
         compare_field("b", snap.b_out, got.b_out);
         compare_field("c", snap.c_out, got.c_out);
         compare_field("d", snap.d_out, got.d_out);
         compare_field("e", snap.e_out, got.e_out);
         compare_field("sp", snap.sp_out, got.sp_out);
         compare_field("status", snap.status_out, got.status_out);
         compare_field("read_data", snap.read_data, got.read_data);
      endfunction

      function int outstanding();
         return expected_regs.size();
      endfunction
   endclass

   logic             clock;
   logic             reset;
   logic             req_tvalid;
   logic             req_tready;
   logic [31:0]      req_tdata;
   logic [1:0]       req_tuser;
   logic             rsp_tvalid;
   logic             rsp_tready;
   logic [RSP_W-1:0] rsp_tdata;

   cpu_state_checker cpu = new();
   bit steady;

   accumulator_cpu_step u_dut (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tuser  (req_tuser),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata)
   );

   initial begin
      clock = 1'b0;
      forever #5 clock = ~clock;
   end

   initial begin
      #5_000_000;
      $display("Testbench completed WITH ERRORS");
      $finish;
   end

   function automatic int gap_length();
      int r;
      if (steady) return 0;
      r = $urandom_range(0, 99);
      if (r < 55) return 0;
      if (r < 92) return $urandom_range(1, 3);
      return $urandom_range(6, 40);
   endfunction

   // Called and returning at a falling edge; the transfer is noted at the rising edge.
   task automatic send_item(input logic [1:0] cmd, input logic [ADDR_W-1:0] addr,
                            input logic [DATA_W-1:0] data);
      int gap;
      gap = gap_length();
      if (gap > 0) begin
         req_tvalid <= 1'b0;
         repeat (gap) @(negedge clock);
      end
      req_tvalid <= 1'b1;
      req_tuser  <= cmd;
      req_tdata  <= {1'b0, data, addr};
      do @(posedge clock); while (!req_tready);
      cpu.apply_command(cmd, addr, data);
      @(negedge clock);
   endtask

   function automatic logic [3:0] pick_reg();
      if ($urandom_range(0, 99) < 85) return 4'($urandom_range(0, 9));
      return 4'($urandom_range(10, 15));
   endfunction

   function automatic logic [DATA_W-1:0] make_instr();
      int r;
      logic [3:0] cond;
      r = $urandom_range(0, 99);
      if (r < 8) return WORD_LOAD;
      if (r < 16) return WORD_STORE;
      cond = ($urandom_range(0, 99) < 30) ? 4'd0 : 4'($urandom_range(0, 15));
      return {pick_reg(), pick_reg(), cond, 4'($urandom_range(0, 15))};
   endfunction

   function automatic logic [DATA_W-1:0] make_operand();
      int r;
      r = $urandom_range(0, 99);
      if (r < 25) return 16'($urandom_range(0, 15));
      if (r < 55) return 16'($urandom_range(0, 63));
      return 16'($urandom);
   endfunction

   // Memory word the instruction at pc will read besides itself, or -1 for none.
   function automatic int operand_index(logic [DATA_W-1:0] w);
      logic [DATA_W-1:0] next_pc, next_sp;
      next_pc = cpu.regs[R_PC] + 16'd1;
      next_sp = cpu.regs[R_SP] + 16'd1;
      if (w == WORD_LOAD) return cpu.wrap(cpu.regs[R_B]);
      case (w[3:0])
         OP_POP: return cpu.wrap(next_sp);
         OP_LDI: return cpu.wrap(next_pc);
         OP_JMPM: begin
            if (cpu.cond_met(w[7:4])) return cpu.wrap(next_pc);
         end
         default: ;
      endcase
      return -1;
   endfunction

   // Places a chosen instruction at pc, supplies its operand if missing, runs it.
   task automatic run_instr(input logic [DATA_W-1:0] w, input logic [DATA_W-1:0] imm);
      int idx;
      send_item(CMD_WRITE, ADDR_W'(cpu.wrap(cpu.regs[R_PC])), w);
      idx = operand_index(w);
      if (idx >= 0 && !cpu.written[idx]) send_item(CMD_WRITE, ADDR_W'(idx), imm);
      send_item(CMD_EXEC, '0, '0);
   endtask

   // One step of a random program: code and operands are written before they are used.
   task automatic program_step();
      int pc_idx, idx;
      pc_idx = cpu.wrap(cpu.regs[R_PC]);
      if (!cpu.written[pc_idx] || $urandom_range(0, 99) < 10) begin
         send_item(CMD_WRITE, ADDR_W'(pc_idx), make_instr());
         return;
      end
      idx = operand_index(cpu.mem[pc_idx]);
      if (idx >= 0 && !cpu.written[idx])
         send_item(CMD_WRITE, ADDR_W'(idx), make_operand());
      else
         send_item(CMD_EXEC, ADDR_W'($urandom), 16'($urandom));
   endtask

   always @(posedge clock) begin
      if (!reset && rsp_tvalid && rsp_tready) cpu.check_snapshot(rsp_type'(rsp_tdata));
   end

   initial begin
      int hold;
      int r;
      bit held;
      hold = 0;
      held = 1'b0;
      rsp_tready = 1'b0;
      @(negedge reset);
      forever begin
         @(negedge clock);
         if (hold > 0) begin
            rsp_tready <= 1'b0;
            hold--;
         end else if (!held && cpu.checked >= 150) begin
            // Long hold-off so the block backs up and refuses request transfers.
            held = 1'b1;
            hold = 400;
            rsp_tready <= 1'b0;
         end else if (steady) begin
            rsp_tready <= 1'b1;
         end else begin
            r = $urandom_range(0, 99);
            if (r < 60) begin
               rsp_tready <= 1'b1;
            end else if (r < 92) begin
               rsp_tready <= 1'b0;
               hold = $urandom_range(0, 3);
            end else begin
               rsp_tready <= 1'b0;
               hold = $urandom_range(5, 40);
            end
         end
      end
   end

   initial begin
      int count;
      int r;
      reset = 1'b1;
      req_tvalid = 1'b0;
      req_tdata = '0;
      req_tuser = CMD_EXEC;
      steady = 1'b0;
      repeat (11) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;
      @(negedge clock);

      // Memory and field extremes, then the unknown command.
      send_item(CMD_WRITE, '1, '1);
      send_item(CMD_READ, '1, '0);
      send_item(CMD_UNKNOWN, '1, '1);
      // Load immediate into status, then a taken inline jump to 0xffff.
      run_instr({R_PC, R_STATUS, 4'h0, OP_LDI}, 16'h0005);
      run_instr({R_PC, R_PC, 4'h5, OP_JMPM}, 16'hffff);
      // At pc 0xffff: fetch wraps pc; a shift by sb (0x8000) gives zero.
      run_instr({R_SB, R_STATUS, 4'h0, OP_SHL}, '0);
      // Moving an out-of-range register into ir must not trigger a second decode.
      run_instr({R_IR, 4'hc, 4'h0, OP_MOVE}, '0);
      // Inline jump whose condition is not met skips its word.
      run_instr({R_PC, R_PC, 4'hf, OP_JMPM}, '0);
      run_instr({R_PC, R_PC, 4'h0, OP_PUSH}, '0);
      run_instr({R_PC, R_PC, 4'h0, OP_POP}, '0);
      run_instr(WORD_LOAD, 16'h1234);
      run_instr(WORD_STORE, '0);

      count = 0;
      while (count < RANDOM_ITEMS) begin
         steady = ((count / 50) % 5) == 2;
         r = $urandom_range(0, 99);
         if (r < 80) begin
            program_step();
            count++;
         end else if (r < 88) begin
            send_item(CMD_WRITE, ADDR_W'($urandom), 16'($urandom));
            count++;
         end else if (r < 96) begin
            send_item(CMD_READ,
                      ADDR_W'(cpu.written_list[$urandom_range(0, cpu.written_list.size() - 1)]),
                      16'($urandom));
            count++;
         end else begin
            send_item(CMD_UNKNOWN, ADDR_W'($urandom), 16'($urandom));
         end
      end
      steady = 1'b0;
      req_tvalid <= 1'b0;

      while (cpu.outstanding() != 0) @(posedge clock);
      repeat (20) @(posedge clock);
      if (cpu.errors == 0 && cpu.outstanding() == 0) begin
         $display("Testbench completed without errors");
      end else begin
         $display("Testbench completed WITH ERRORS");
      end
      $finish;
   end

endmodule
